### sv/sui_pkg.sv
// shared types, field widths and codes of the sorted unique insert list
package sui_pkg;

    localparam int KEY_BITS    = 32;
    localparam int POS_BITS    = 6;
    localparam int COUNT_BITS  = 7;
    localparam int STATUS_BITS = 3;
    localparam int OP_BITS     = 2;

    // operation codes
    localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_READ   = 2'd2;

    // result status codes
    localparam logic [STATUS_BITS-1:0] ST_INSERTED   = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_DUPLICATE  = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL       = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_READ_OK    = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_READ_RANGE = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_CLEARED    = 3'd5;

    typedef struct packed {
        logic [OP_BITS-1:0]  op;
        logic [KEY_BITS-1:0] key;
        logic [POS_BITS-1:0] read_position;
    } sui_req_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [KEY_BITS-1:0]    value;
        logic [COUNT_BITS-1:0]  entry_count;
        logic [POS_BITS-1:0]    position;
    } sui_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE,
        S_READ_WAIT,
        S_EMIT
    } sui_state_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_IDX_DEC,
        RD_POS
    } sui_rd_src_t;

    typedef enum logic {
        WR_SHIFT,
        WR_KEY
    } sui_wr_src_t;

    // controller to datapath
    typedef struct packed {
        logic                   load;
        logic                   idx_clear;
        logic                   idx_inc;
        logic                   idx_dec;
        logic                   idx_from_count;
        logic                   set_slot;
        logic                   slot_dup_chk;
        logic                   mem_rd;
        sui_rd_src_t            rd_src;
        logic                   mem_wr;
        sui_wr_src_t            wr_src;
        logic                   count_inc;
        logic                   count_clear;
        logic                   set_status;
        logic [STATUS_BITS-1:0] status_code;
        logic                   rsp_load;
    } sui_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [OP_BITS-1:0] op;
        logic               at_end;
        logic               key_ge;
        logic               dup;
        logic               full;
        logic               shift_done;
        logic               rp_in_range;
    } sui_status_t;

endpackage

### sv/sui_ctrl.sv
// controller state machine of the sorted unique insert list
module sui_ctrl
    import sui_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    input  sui_status_t status,
    output sui_cmd_t    cmd
);

    sui_state_t state_reg;
    sui_state_t state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       rsp_free;

    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.op)
                    OP_INSERT: state_next = S_SEARCH_RD;
                    OP_CLEAR:  state_next = S_EMIT;
                    OP_READ:   state_next = status.rp_in_range ? S_READ_WAIT : S_EMIT;
                    default:   state_next = status.rp_in_range ? S_READ_WAIT : S_EMIT;
                endcase
            end
            S_SEARCH_RD:
            begin
                state_next = status.at_end ? S_DECIDE : S_SEARCH_CMP;
            end
            S_SEARCH_CMP:
            begin
                state_next = status.key_ge ? S_DECIDE : S_SEARCH_RD;
            end
            S_DECIDE:
            begin
                if (status.dup || status.full)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD:
            begin
                state_next = status.shift_done ? S_PLACE : S_SHIFT_WR;
            end
            S_SHIFT_WR:  state_next = S_SHIFT_RD;
            S_PLACE:     state_next = S_EMIT;
            S_READ_WAIT: state_next = S_EMIT;
            S_EMIT:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb
    begin
        cmd        = '0;
        cmd.rd_src = RD_IDX;
        cmd.wr_src = WR_SHIFT;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = req_valid;
            end
            S_DISPATCH:
            begin
                case (status.op)
                    OP_INSERT:
                    begin
                        cmd.idx_clear = 1'b1;
                    end
                    OP_CLEAR:
                    begin
                        cmd.count_clear = 1'b1;
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_CLEARED;
                    end
                    default:
                    begin
                        // read, also for the unused fourth code
                        cmd.mem_rd      = status.rp_in_range;
                        cmd.rd_src      = RD_POS;
                        cmd.set_status  = !status.rp_in_range;
                        cmd.status_code = ST_READ_RANGE;
                    end
                endcase
            end
            S_SEARCH_RD:
            begin
                cmd.set_slot = status.at_end;
                cmd.mem_rd   = !status.at_end;
                cmd.rd_src   = RD_IDX;
            end
            S_SEARCH_CMP:
            begin
                cmd.set_slot     = status.key_ge;
                cmd.slot_dup_chk = status.key_ge;
                cmd.idx_inc      = !status.key_ge;
            end
            S_DECIDE:
            begin
                if (status.dup)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_DUPLICATE;
                end
                else if (status.full)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_FULL;
                end
                else
                begin
                    cmd.idx_from_count = 1'b1;
                end
            end
            S_SHIFT_RD:
            begin
                cmd.mem_rd = !status.shift_done;
                cmd.rd_src = RD_IDX_DEC;
            end
            S_SHIFT_WR:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_src  = WR_SHIFT;
                cmd.idx_dec = 1'b1;
            end
            S_PLACE:
            begin
                cmd.mem_wr      = 1'b1;
                cmd.wr_src      = WR_KEY;
                cmd.count_inc   = 1'b1;
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_INSERTED;
            end
            S_READ_WAIT:
            begin
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_READ_OK;
            end
            S_EMIT:
            begin
                cmd.rsp_load = rsp_free;
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // a finished result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rsp_load |-> (!rsp_valid_reg || rsp_ready))
        else $error("result loaded over a pending result");

    // an accepted request is dispatched in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_DISPATCH))
        else $error("accepted request not dispatched");

    // a loaded result is offered in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rsp_load |=> rsp_valid_reg)
        else $error("loaded result not offered");

endmodule

### sv/sui_datapath.sv
// datapath of the sorted unique insert list: entry memory, index, count, result register
module sui_datapath
    import sui_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  sui_req_t    req,
    input  sui_cmd_t    cmd,
    output sui_status_t status,
    output sui_rsp_t    rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_BITS) ? CW : POS_BITS;

    logic [KEY_BITS-1:0]    entries_mem [CAPACITY];
    logic [KEY_BITS-1:0]    rdata_reg;

    logic [OP_BITS-1:0]     op_reg,  op_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [POS_BITS-1:0]    rp_reg,  rp_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          slot_reg, slot_next;
    logic                   dup_reg, dup_next;
    logic [STATUS_BITS-1:0] res_status_reg, res_status_next;
    sui_rsp_t               rsp_reg, rsp_next;

    logic [CW-1:0]          idx_dec;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          wr_addr;
    logic [KEY_BITS-1:0]    wr_data;
    logic                   key_eq;

    assign idx_dec = idx_reg - CW'(1);
    assign key_eq  = (rdata_reg == key_reg);

    // status to the controller
    assign status.op          = op_reg;
    assign status.at_end      = (idx_reg == count_reg);
    assign status.key_ge      = (rdata_reg >= key_reg);
    assign status.dup         = dup_reg;
    assign status.full        = (count_reg == CW'(CAPACITY));
    assign status.shift_done  = (idx_reg == slot_reg);
    assign status.rp_in_range = (XW'(rp_reg) < XW'(count_reg));

    // memory address and data selection
    always_comb
    begin
        case (cmd.rd_src)
            RD_IDX:     rd_addr = idx_reg[AW-1:0];
            RD_IDX_DEC: rd_addr = idx_dec[AW-1:0];
            RD_POS:     rd_addr = AW'(rp_reg);
            default:    rd_addr = idx_reg[AW-1:0];
        endcase
        if (cmd.wr_src == WR_KEY)
        begin
            wr_addr = slot_reg[AW-1:0];
            wr_data = key_reg;
        end
        else
        begin
            wr_addr = idx_reg[AW-1:0];
            wr_data = rdata_reg;
        end
    end

    // entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            entries_mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= entries_mem[rd_addr];
        end
    end

    // request, index, slot and status next values
    always_comb
    begin
        op_next         = cmd.load ? req.op : op_reg;
        key_next        = cmd.load ? req.key : key_reg;
        rp_next         = cmd.load ? req.read_position : rp_reg;
        slot_next       = cmd.set_slot ? idx_reg : slot_reg;
        dup_next        = cmd.set_slot ? (cmd.slot_dup_chk && key_eq) : dup_reg;
        res_status_next = cmd.set_status ? cmd.status_code : res_status_reg;

        idx_next = idx_reg;
        if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_from_count)
        begin
            idx_next = count_reg;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CW'(1);
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_dec;
        end

        count_next = count_reg;
        if (cmd.count_clear)
        begin
            count_next = '0;
        end
        else if (cmd.count_inc)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    // result assembly
    always_comb
    begin
        rsp_next.status      = res_status_reg;
        rsp_next.entry_count = COUNT_BITS'(count_reg);
        rsp_next.value       = '0;
        rsp_next.position    = '0;
        case (res_status_reg)
            ST_INSERTED, ST_DUPLICATE:
            begin
                rsp_next.value    = key_reg;
                rsp_next.position = POS_BITS'(slot_reg);
            end
            ST_FULL:
            begin
                rsp_next.value = key_reg;
            end
            ST_READ_OK:
            begin
                rsp_next.value    = rdata_reg;
                rsp_next.position = rp_reg;
            end
            ST_READ_RANGE:
            begin
                rsp_next.position = rp_reg;
            end
            default:
            begin
                rsp_next.value = '0;
            end
        endcase
    end

    assign rsp = rsp_reg;

    // entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        rp_reg         <= rp_next;
        idx_reg        <= idx_next;
        slot_reg       <= slot_next;
        dup_reg        <= dup_next;
        res_status_reg <= res_status_next;
        if (cmd.rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // the list never holds more than its capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // a key is never placed into a full list
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.count_inc |-> (count_reg != CW'(CAPACITY)))
        else $error("insert into a full list");

    // every write lands inside the memory
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_wr |-> (((cmd.wr_src == WR_KEY) ? slot_reg : idx_reg) < CW'(CAPACITY)))
        else $error("entry write beyond capacity");

endmodule

### sv/sorted_unique_insert_list.sv
// top level of the sorted unique insert list: controller and datapath
//
//  channel   valid      ready      payload   carries
//  request   req_valid  req_ready  req       op, key, read_position
//  result    rsp_valid  rsp_ready  rsp       status, value, entry_count, position
//
// one request is worked at a time; each swept slot takes a read state, then a compare or write state
// insert: search sweep up from slot 0, shift sweep down from the end to the slot, then place
// read: dispatch, read wait and emit; clear and out-of-range read: dispatch and emit
// reset clears the entry count and the controller state only; no clearing pass over the memory
// a new request is taken while the previous result still waits in the output register
module sorted_unique_insert_list
    import sui_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  sui_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output sui_rsp_t rsp
);

    sui_cmd_t    cmd;
    sui_status_t status;

    // sequencing
    sui_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // storage and compares
    sui_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .rsp    (rsp)
    );

endmodule
